/* sv/mtwtc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the MIDI time-window trim with chase.
package mtwtc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_BEGIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_EN      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHASE_EN    = 2'd3;

  localparam logic [2:0] KIND_NOTE   = 3'd0;
  localparam logic [2:0] KIND_BEND   = 3'd1;
  localparam logic [2:0] KIND_CTRL   = 3'd2;
  localparam logic [2:0] KIND_PROG   = 3'd3;
  localparam logic [2:0] KIND_CTOUCH = 3'd4;
  localparam logic [2:0] KIND_KTOUCH = 3'd5;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic        valid;
    logic [31:0] tick;
    logic [6:0]  value;
  } ctl_entry_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] tick;
    logic [13:0] value;
    logic        flag;
  } chn_entry_t;

  typedef struct packed {
    logic        mode;
    logic [2:0]  kind;
    logic [3:0]  channel;
    logic [6:0]  number;
    logic [13:0] value;
    logic        flag;
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic        ctl_ok;
    logic        chn_ok;
  } item_t;

endpackage

/* sv/midi_time_window_trim_with_chase.sv */
`timescale 1ns / 1ps
// MIDI event window trim with controller chase tables in synchronous RAM.
// Each item is registered into the execute stage, then into the output registers; one item per cycle while busy is low.
// Throughput is set by the single read-modify-write per item on each chase RAM,
// with write-to-read forwarding for back-to-back hits on the same entry.
// Reset: busy stays high while both chase RAMs are swept clear over max(2*CHANNELS*NUMBERS,
// 3*CHANNELS) addresses (4096 by default).
module midi_time_window_trim_with_chase #(
  parameter int CHANNELS = 16,
  parameter int NUMBERS  = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cfg_we_i,
  input  logic [mtwtc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mtwtc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                mode_i,
  input  logic [2:0]                          kind_i,
  input  logic [3:0]                          channel_i,
  input  logic [6:0]                          number_i,
  input  logic [13:0]                         value_i,
  input  logic                                flag_i,
  input  logic [31:0]                         start_time_i,
  input  logic [31:0]                         end_time_i,
  output logic                                out_valid_o,
  output logic [2:0]                          out_kind_o,
  output logic [3:0]                          out_channel_o,
  output logic [6:0]                          out_number_o,
  output logic [13:0]                         out_value_o,
  output logic                                out_flag_o,
  output logic [31:0]                         out_start_o,
  output logic [31:0]                         out_end_o
);
  import mtwtc_pkg::*;

  localparam int CTL_DEPTH = 2 * CHANNELS * NUMBERS;
  localparam int CHN_DEPTH = 3 * CHANNELS;
  localparam int CLR_DEPTH = (CTL_DEPTH > CHN_DEPTH) ? CTL_DEPTH : CHN_DEPTH;
  localparam int CTL_AW    = $clog2(CTL_DEPTH);
  localparam int CHN_AW    = $clog2(CHN_DEPTH);
  localparam int CLR_AW    = $clog2(CLR_DEPTH);

  // configuration
  logic [31:0] range_begin_q, range_end_q;
  logic        end_en_q, chase_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_begin_q <= '0;
      range_end_q   <= '1;
      end_en_q      <= 1'b1;
      chase_en_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RANGE_BEGIN: range_begin_q <= cfg_data_i[31:0];
        CFG_RANGE_END:   range_end_q   <= cfg_data_i[31:0];
        CFG_END_EN:      end_en_q      <= cfg_data_i[0];
        CFG_CHASE_EN:    chase_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clear sweep control
  state_e              state_q, state_d;
  logic [CLR_AW-1:0]   clr_cnt_q;
  logic                clearing, clr_ctl_en, clr_chn_en;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == CLR_AW'(CLR_DEPTH - 1)) state_d = ST_RUN;
      end
      ST_RUN:   state_d = ST_RUN;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    clearing   = 1'b0;
    clr_ctl_en = 1'b0;
    clr_chn_en = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clearing   = 1'b1;
        clr_ctl_en = {1'b0, clr_cnt_q} < (CLR_AW + 1)'(CTL_DEPTH);
        clr_chn_en = {1'b0, clr_cnt_q} < (CLR_AW + 1)'(CHN_DEPTH);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (clearing) clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign busy = clearing;

  // accept and address decode
  logic              accept;
  logic              ch_ok, num_ok, ctl_ok_in;
  logic [CTL_AW-1:0] ctl_row, ctl_raddr;
  logic [CHN_AW-1:0] chn_base, chn_raddr;

  assign accept    = start && !busy;
  assign ch_ok     = {1'b0, channel_i} < 5'(CHANNELS);
  assign num_ok    = {1'b0, number_i} < 8'(NUMBERS);
  assign ctl_ok_in = ch_ok && num_ok;

  always_comb begin
    ctl_row  = ((kind_i == KIND_KTOUCH) ? CTL_AW'(CHANNELS) : '0) + CTL_AW'(channel_i);
    ctl_raddr = ctl_ok_in ? CTL_AW'(ctl_row * CTL_AW'(NUMBERS)) + CTL_AW'(number_i) : '0;
    if (kind_i == KIND_BEND) begin
      chn_base = '0;
    end else if (kind_i == KIND_PROG) begin
      chn_base = CHN_AW'(CHANNELS);
    end else begin
      chn_base = CHN_AW'(2 * CHANNELS);
    end
    chn_raddr = ch_ok ? chn_base + CHN_AW'(channel_i) : '0;
  end

  // execute stage
  item_t             s1_q;
  logic              s1_valid_q;
  logic [CTL_AW-1:0] s1_ctl_addr_q;
  logic [CHN_AW-1:0] s1_chn_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= '{mode: mode_i, kind: kind_i, channel: channel_i, number: number_i,
                value: value_i, flag: flag_i, start_time: start_time_i,
                end_time: end_time_i, ctl_ok: ctl_ok_in, chn_ok: ch_ok};
      s1_ctl_addr_q <= ctl_raddr;
      s1_chn_addr_q <= chn_raddr;
    end
  end

  // chase memories
  ctl_entry_t ctl_mem [CTL_DEPTH];
  chn_entry_t chn_mem [CHN_DEPTH];
  ctl_entry_t ctl_rd_q, ctl_fwd_q, ctl_cur, ctl_new, ctl_wdata;
  chn_entry_t chn_rd_q, chn_fwd_q, chn_cur, chn_new, chn_wdata;
  logic       ctl_hit_q, chn_hit_q;
  logic       ctl_chase_we, chn_chase_we, ctl_we, chn_we;
  logic [CTL_AW-1:0] ctl_waddr;
  logic [CHN_AW-1:0] chn_waddr;

  assign ctl_we    = clearing ? clr_ctl_en : ctl_chase_we;
  assign chn_we    = clearing ? clr_chn_en : chn_chase_we;
  assign ctl_waddr = clearing ? clr_cnt_q[CTL_AW-1:0] : s1_ctl_addr_q;
  assign chn_waddr = clearing ? clr_cnt_q[CHN_AW-1:0] : s1_chn_addr_q;
  assign ctl_wdata = clearing ? '0 : ctl_new;
  assign chn_wdata = clearing ? '0 : chn_new;

  always_ff @(posedge clk_i) begin
    if (ctl_we) ctl_mem[ctl_waddr] <= ctl_wdata;
    if (accept) ctl_rd_q <= ctl_mem[ctl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (chn_we) chn_mem[chn_waddr] <= chn_wdata;
    if (accept) chn_rd_q <= chn_mem[chn_raddr];
  end

  // forward a write that lands on the entry read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_hit_q <= 1'b0;
      chn_hit_q <= 1'b0;
    end else begin
      ctl_hit_q <= accept && ctl_chase_we && (s1_ctl_addr_q == ctl_raddr);
      chn_hit_q <= accept && chn_chase_we && (s1_chn_addr_q == chn_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctl_fwd_q <= ctl_new;
      chn_fwd_q <= chn_new;
    end
  end

  assign ctl_cur = ctl_hit_q ? ctl_fwd_q : ctl_rd_q;
  assign chn_cur = chn_hit_q ? chn_fwd_q : chn_rd_q;

  // chase update
  logic is_ctl_kind, is_chn_kind, chase_ok;

  assign is_ctl_kind = (s1_q.kind == KIND_CTRL) || (s1_q.kind == KIND_KTOUCH);
  assign is_chn_kind = (s1_q.kind == KIND_BEND) || (s1_q.kind == KIND_PROG) ||
                       (s1_q.kind == KIND_CTOUCH);
  assign chase_ok    = s1_valid_q && !s1_q.mode && chase_en_q &&
                       (s1_q.start_time <= range_begin_q);

  assign ctl_chase_we = chase_ok && is_ctl_kind && s1_q.ctl_ok &&
                        (!ctl_cur.valid || (s1_q.start_time >= ctl_cur.tick));
  assign chn_chase_we = chase_ok && is_chn_kind && s1_q.chn_ok &&
                        (!chn_cur.valid || (s1_q.start_time >= chn_cur.tick));

  assign ctl_new = '{valid: 1'b1, tick: s1_q.start_time, value: s1_q.value[6:0]};
  assign chn_new = '{valid: 1'b1, tick: s1_q.start_time, value: s1_q.value,
                     flag: s1_q.flag};

  // result
  logic [31:0] start_rel, end_rel, win_len;
  logic        res_valid_d, note_drop;
  logic [6:0]  res_number_d;
  logic [13:0] res_value_d;
  logic        res_flag_d;
  logic [31:0] res_start_d, res_end_d;

  assign start_rel = s1_q.start_time - range_begin_q;
  assign end_rel   = s1_q.end_time - range_begin_q;
  assign win_len   = (range_end_q >= range_begin_q) ? range_end_q - range_begin_q : '0;
  assign note_drop = (s1_q.end_time <= range_begin_q) ||
                     (end_en_q && (s1_q.start_time >= range_end_q));

  always_comb begin
    res_valid_d  = 1'b0;
    res_number_d = s1_q.number;
    res_value_d  = s1_q.value;
    res_flag_d   = s1_q.flag;
    res_start_d  = '0;
    res_end_d    = '0;
    if (s1_q.mode) begin
      if (is_ctl_kind) begin
        res_valid_d = s1_q.ctl_ok && ctl_cur.valid && (ctl_cur.tick < range_begin_q);
        res_value_d = {7'd0, ctl_cur.value};
        res_flag_d  = 1'b0;
      end else if (is_chn_kind) begin
        res_valid_d  = s1_q.chn_ok && chn_cur.valid && (chn_cur.tick < range_begin_q);
        res_number_d = '0;
        res_value_d  = chn_cur.value;
        res_flag_d   = (s1_q.kind == KIND_PROG) ? chn_cur.flag : 1'b0;
      end
    end else if (s1_q.kind == KIND_NOTE) begin
      res_valid_d = !note_drop;
      res_start_d = (s1_q.start_time >= range_begin_q) ? start_rel : '0;
      res_end_d   = (!end_en_q || (s1_q.end_time <= range_end_q)) ? end_rel : win_len;
    end else begin
      res_valid_d = (s1_q.start_time >= range_begin_q) &&
                    (!end_en_q || (s1_q.start_time <= range_end_q));
      res_start_d = start_rel;
    end
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s1_valid_q && res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && res_valid_d) begin
      out_kind_o    <= s1_q.kind;
      out_channel_o <= s1_q.channel;
      out_number_o  <= res_number_d;
      out_value_o   <= res_value_d;
      out_flag_o    <= res_flag_d;
      out_start_o   <= res_start_d;
      out_end_o     <= res_end_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_no_result_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !out_valid_q)
    else $error("result strobe during clear sweep");

  a_result_follows_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $past(s1_valid_q))
    else $error("result without an item in execute stage");

  a_fwd_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_hit_q || chn_hit_q) |-> s1_valid_q)
    else $error("forwarding flag without an item");

  a_read_never_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_chase_we || chn_chase_we) |-> (!s1_q.mode && !clearing))
    else $error("chase write from a read item or during clear");
`endif

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the MIDI time-window trim with controller chase.
module tb_top;
  import mtwtc_pkg::*;

  localparam logic [2:0]  KIND_OTHER  = 3'd6;
  localparam logic [2:0]  KIND_SPARE  = 3'd7;
  localparam logic        MODE_TRIM   = 1'b0;
  localparam logic        MODE_READ   = 1'b1;
  localparam logic [31:0] TICK_MAX    = 32'hFFFF_FFFF;
  localparam int          STALL_LIMIT = 20000;
  localparam int          SHOW_MAX    = 10;

  typedef struct packed {
    logic        mode;
    logic [2:0]  kind;
    logic [3:0]  channel;
    logic [6:0]  number;
    logic [13:0] value;
    logic        flag;
    logic [31:0] start_time;
    logic [31:0] end_time;
  } midi_event_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  channel;
    logic [6:0]  number;
    logic [13:0] value;
    logic        flag;
    logic [31:0] start_tick;
    logic [31:0] end_tick;
  } midi_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  mode_i;
  logic [2:0]            kind_i;
  logic [3:0]            channel_i;
  logic [6:0]            number_i;
  logic [13:0]           value_i;
  logic                  flag_i;
  logic [31:0]           start_time_i;
  logic [31:0]           end_time_i;
  logic                  out_valid_o;
  logic [2:0]            out_kind_o;
  logic [3:0]            out_channel_o;
  logic [6:0]            out_number_o;
  logic [13:0]           out_value_o;
  logic                  out_flag_o;
  logic [31:0]           out_start_o;
  logic [31:0]           out_end_o;

  // Window registers and chase tables as the block should hold them.
  logic [31:0] win_begin = 32'd0;
  logic [31:0] win_end   = TICK_MAX;
  bit          end_on    = 1'b1;
  bit          chase_on  = 1'b0;
  bit          ctl_valid [4096];
  logic [31:0] ctl_tick  [4096];
  logic [6:0]  ctl_val   [4096];
  bit          chn_valid [48];
  logic [31:0] chn_tick  [48];
  logic [13:0] chn_val   [48];
  logic        chn_flag  [48];

  midi_result_t expected_events[$];
  int           errors = 0;
  int           shown = 0;
  int           quiet_cycles = 0;
  bit           narrow_keys = 1'b0;

  midi_time_window_trim_with_chase dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .mode_i        (mode_i),
    .kind_i        (kind_i),
    .channel_i     (channel_i),
    .number_i      (number_i),
    .value_i       (value_i),
    .flag_i        (flag_i),
    .start_time_i  (start_time_i),
    .end_time_i    (end_time_i),
    .out_valid_o   (out_valid_o),
    .out_kind_o    (out_kind_o),
    .out_channel_o (out_channel_o),
    .out_number_o  (out_number_o),
    .out_value_o   (out_value_o),
    .out_flag_o    (out_flag_o),
    .out_start_o   (out_start_o),
    .out_end_o     (out_end_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic bit trim_or_read(input midi_event_t ev, output midi_result_t res);
    bit          is_ctl;
    bit          is_chn;
    logic [11:0] ci;
    logic [5:0]  hi;
    logic [31:0] wlen;
    is_ctl = (ev.kind == KIND_CTRL) || (ev.kind == KIND_KTOUCH);
    is_chn = (ev.kind == KIND_BEND) || (ev.kind == KIND_PROG) || (ev.kind == KIND_CTOUCH);
    ci = {ev.kind == KIND_KTOUCH, ev.channel, ev.number};
    hi = (ev.kind == KIND_BEND ? 6'd0 : ev.kind == KIND_PROG ? 6'd16 : 6'd32) + ev.channel;
    res = '0;
    res.kind = ev.kind;
    res.channel = ev.channel;
    if (ev.mode == MODE_READ) begin
      if (is_ctl && ctl_valid[ci] && ctl_tick[ci] < win_begin) begin
        res.number = ev.number;
        res.value = {7'd0, ctl_val[ci]};
        return 1'b1;
      end
      if (is_chn && chn_valid[hi] && chn_tick[hi] < win_begin) begin
        res.value = chn_val[hi];
        res.flag = (ev.kind == KIND_PROG) ? chn_flag[hi] : 1'b0;
        return 1'b1;
      end
      return 1'b0;
    end
    if (chase_on && ev.start_time <= win_begin) begin
      if (is_ctl && (!ctl_valid[ci] || ev.start_time >= ctl_tick[ci])) begin
        ctl_valid[ci] = 1'b1;
        ctl_tick[ci] = ev.start_time;
        ctl_val[ci] = ev.value[6:0];
      end else if (is_chn && (!chn_valid[hi] || ev.start_time >= chn_tick[hi])) begin
        chn_valid[hi] = 1'b1;
        chn_tick[hi] = ev.start_time;
        chn_val[hi] = ev.value;
        chn_flag[hi] = ev.flag;
      end
    end
    res.number = ev.number;
    res.value = ev.value;
    res.flag = ev.flag;
    if (ev.kind == KIND_NOTE) begin
      if (ev.end_time <= win_begin || (end_on && ev.start_time >= win_end)) return 1'b0;
      res.start_tick = (ev.start_time >= win_begin) ? ev.start_time - win_begin : 32'd0;
      wlen = (win_end >= win_begin) ? win_end - win_begin : 32'd0;
      res.end_tick = (!end_on || ev.end_time <= win_end) ? ev.end_time - win_begin : wlen;
      return 1'b1;
    end
    if (ev.start_time >= win_begin && (!end_on || ev.start_time <= win_end)) begin
      res.start_tick = ev.start_time - win_begin;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic string show(input midi_result_t r);
    return $sformatf("kind %0d ch %0d num %0d val %0d flag %0d start %h end %h",
                     r.kind, r.channel, r.number, r.value, r.flag, r.start_tick, r.end_tick);
  endfunction

  always @(posedge clk_i) begin : check_results
    midi_result_t got;
    midi_result_t want;
    if (out_valid_o === 1'b1) begin
      got = {out_kind_o, out_channel_o, out_number_o, out_value_o, out_flag_o,
             out_start_o, out_end_o};
      if (expected_events.size() == 0) begin
        errors++;
        if (shown < SHOW_MAX) begin
          shown++;
          $display("unexpected result: %s", show(got));
        end
      end else begin
        want = expected_events.pop_front();
        if (got.kind !== want.kind || got.channel !== want.channel ||
            got.number !== want.number || got.value !== want.value ||
            got.flag !== want.flag || got.start_tick !== want.start_tick ||
            got.end_tick !== want.end_tick) begin
          errors++;
          if (shown < SHOW_MAX) begin
            shown++;
            $display("result mismatch: expected %s", show(want));
            $display("                 actual   %s", show(got));
          end
        end
      end
    end
  end

  // Counts cycles with neither an accepted item nor a result.
  always @(posedge clk_i) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_event(input midi_event_t ev);
    midi_result_t res;
    mode_i       <= ev.mode;
    kind_i       <= ev.kind;
    channel_i    <= ev.channel;
    number_i     <= ev.number;
    value_i      <= ev.value;
    flag_i       <= ev.flag;
    start_time_i <= ev.start_time;
    end_time_i   <= ev.end_time;
    start        <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (trim_or_read(ev, res)) expected_events.insert(expected_events.size(), res);
    @(negedge clk_i);
  endtask

  task automatic put(input logic m, input logic [2:0] k, input logic [3:0] ch,
                     input logic [6:0] num, input logic [13:0] val, input logic fl,
                     input logic [31:0] ts, input logic [31:0] te);
    send_event({m, k, ch, num, val, fl, ts, te});
  endtask

  task automatic maybe_gap(input int gap_pct);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
  endtask

  // Hold off until every result is in, then let the pipeline run empty.
  task automatic settle();
    start <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_RANGE_BEGIN: win_begin = data;
      CFG_RANGE_END:   win_end = data;
      CFG_END_EN:      end_on = data[0];
      default:         chase_on = data[0];
    endcase
    @(negedge clk_i);
  endtask

  task automatic apply_window(input logic [31:0] rb, input logic [31:0] re,
                              input bit ee, input bit ce);
    settle();
    write_reg(CFG_RANGE_BEGIN, rb);
    write_reg(CFG_RANGE_END, re);
    write_reg(CFG_END_EN, ($urandom() & 32'hFFFF_FFFE) | ee);
    write_reg(CFG_CHASE_EN, ($urandom() & 32'hFFFF_FFFE) | ce);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_tick();
    logic [31:0] t;
    case ($urandom_range(0, 9))
      0:       t = 32'd0;
      1:       t = TICK_MAX;
      2:       t = $urandom();
      3, 4:    t = win_begin + $urandom_range(0, 4) - 32'd2;
      5:       t = win_begin - $urandom_range(0, 200);
      6:       t = win_end + $urandom_range(0, 4) - 32'd2;
      7:       t = win_begin + $urandom_range(0, 300);
      default: t = win_end - $urandom_range(0, 300);
    endcase
    return t;
  endfunction

  function automatic midi_event_t rand_event();
    midi_event_t ev;
    ev.mode = ($urandom_range(0, 99) < 30) ? MODE_READ : MODE_TRIM;
    ev.kind = ($urandom_range(0, 19) == 0) ? KIND_SPARE : 3'($urandom_range(0, 6));
    ev.channel = narrow_keys ? 4'($urandom_range(0, 1)) : 4'($urandom_range(0, 15));
    ev.number = narrow_keys ? 7'($urandom_range(0, 3)) : 7'($urandom_range(0, 127));
    ev.value = 14'($urandom_range(0, 16383));
    ev.flag = 1'($urandom_range(0, 1));
    ev.start_time = pick_tick();
    ev.end_time = $urandom_range(0, 1) ? pick_tick() : ev.start_time + $urandom_range(0, 500);
    return ev;
  endfunction

  task automatic test_reset_defaults();
    put(MODE_TRIM, KIND_NOTE, 4'd0, 7'd0, 14'd0, 1'b0, 32'd0, 32'd0);
    put(MODE_TRIM, KIND_NOTE, 4'd5, 7'd64, 14'd100, 1'b1, 32'd0, TICK_MAX);
    put(MODE_TRIM, KIND_CTRL, 4'd15, 7'd127, 14'd16383, 1'b1, TICK_MAX, 32'd0);
    put(MODE_TRIM, KIND_SPARE, 4'd2, 7'd9, 14'd33, 1'b0, 32'd5, 32'd1);
    put(MODE_READ, KIND_CTRL, 4'd15, 7'd127, 14'd0, 1'b0, 32'd0, 32'd0);
  endtask

  task automatic test_window_edges();
    apply_window(32'd1000, 32'd2000, 1'b1, 1'b1);
    put(MODE_TRIM, KIND_NOTE, 4'd1, 7'd60, 14'd90, 1'b0, 32'd900, 32'd1500);
    put(MODE_TRIM, KIND_NOTE, 4'd1, 7'd61, 14'd91, 1'b0, 32'd1500, 32'd2500);
    put(MODE_TRIM, KIND_NOTE, 4'd1, 7'd62, 14'd92, 1'b0, 32'd2000, 32'd2100);
    // note that ends before it starts
    put(MODE_TRIM, KIND_NOTE, 4'd1, 7'd63, 14'd93, 1'b0, 32'd1800, 32'd1200);
    // control value keeps only its low 7 bits; tie goes to the later item
    put(MODE_TRIM, KIND_CTRL, 4'd3, 7'd5, 14'd16383, 1'b0, 32'd400, 32'd0);
    put(MODE_TRIM, KIND_CTRL, 4'd3, 7'd5, 14'h0055, 1'b1, 32'd400, 32'd0);
    put(MODE_TRIM, KIND_CTRL, 4'd3, 7'd5, 14'd9, 1'b0, 32'd300, 32'd0);
    put(MODE_TRIM, KIND_BEND, 4'd0, 7'd11, 14'd16383, 1'b0, 32'd999, 32'd0);
    put(MODE_TRIM, KIND_PROG, 4'd9, 7'd0, 14'd77, 1'b1, 32'd10, 32'd0);
    put(MODE_TRIM, KIND_CTOUCH, 4'd2, 7'd0, 14'd1, 1'b0, 32'd1000, 32'd0);
    put(MODE_TRIM, KIND_KTOUCH, 4'd1, 7'd60, 14'd200, 1'b0, 32'd0, 32'd0);
    put(MODE_TRIM, KIND_OTHER, 4'd7, 7'd3, 14'd4, 1'b1, 32'd2000, 32'd0);
    put(MODE_READ, KIND_CTRL, 4'd3, 7'd5, 14'd0, 1'b0, 32'd0, 32'd0);
    put(MODE_READ, KIND_BEND, 4'd0, 7'd11, 14'd0, 1'b0, 32'd0, 32'd0);
    put(MODE_READ, KIND_PROG, 4'd9, 7'd0, 14'd0, 1'b0, 32'd0, 32'd0);
    put(MODE_READ, KIND_CTOUCH, 4'd2, 7'd0, 14'd0, 1'b0, 32'd0, 32'd0);
    put(MODE_READ, KIND_KTOUCH, 4'd1, 7'd60, 14'd0, 1'b1, 32'd0, 32'd0);
  endtask

  task automatic test_open_and_inverted();
    // end below begin: window length saturates at zero
    apply_window(32'd100, 32'd50, 1'b1, 1'b0);
    put(MODE_TRIM, KIND_NOTE, 4'd4, 7'd40, 14'd50, 1'b0, 32'd10, 32'd200);
    apply_window(32'd100, 32'd50, 1'b0, 1'b0);
    put(MODE_TRIM, KIND_CTRL, 4'd4, 7'd7, 14'd99, 1'b0, 32'd5000, 32'd0);
    put(MODE_TRIM, KIND_NOTE, 4'd4, 7'd41, 14'd51, 1'b1, 32'd5000, 32'd7000);
  endtask

  task automatic run_phase(input logic [31:0] rb, input logic [31:0] re, input bit ee,
                           input bit ce, input bit narrow, input int gap_pct, input int n);
    apply_window(rb, re, ee, ce);
    narrow_keys = narrow;
    repeat (n) begin
      send_event(rand_event());
      maybe_gap(gap_pct);
    end
  endtask

  task automatic test_random_windows();
    logic [31:0] rb;
    run_phase(32'd1000, 32'd5000, 1'b1, 1'b1, 1'b1, 25, 120);
    rb = $urandom();
    run_phase(rb, rb + $urandom_range(0, 100000), 1'b1, 1'b1, 1'b1, 40, 120);
    run_phase(32'd0, TICK_MAX, 1'b1, 1'b1, 1'b0, 0, 100);
    run_phase(TICK_MAX, TICK_MAX, 1'b1, 1'b1, 1'b1, 25, 100);
    run_phase($urandom(), $urandom(), 1'b0, 1'b1, 1'b1, 30, 110);
    run_phase(TICK_MAX, 32'd0, 1'b1, 1'b0, 1'b0, 20, 70);
    run_phase(32'd0, 32'd0, 1'b1, 1'b1, 1'b1, 25, 70);
    run_phase(32'd2000, 32'd9000, 1'b1, 1'b1, 1'b1, 0, 130);
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    mode_i       = 1'b0;
    kind_i       = '0;
    channel_i    = '0;
    number_i     = '0;
    value_i      = '0;
    flag_i       = 1'b0;
    start_time_i = '0;
    end_time_i   = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    // chase tables are swept clear after reset
    do @(posedge clk_i); while (busy !== 1'b0);
    @(negedge clk_i);

    test_reset_defaults();
    test_window_edges();
    test_open_and_inverted();
    test_random_windows();

    start <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    errors += expected_events.size();
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* midi_time_window_trim_with_chase.f */
sv/mtwtc_pkg.sv
sv/midi_time_window_trim_with_chase.sv
bench/tb_top.sv
